>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> hw/rtl/okl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package okl_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_READ   = 3'd3,
    CMD_CLEAR  = 3'd4
  } okl_cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_MISSING = 3'd3,
    ST_RANGE   = 3'd4,
    ST_FULL    = 3'd5
  } okl_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_RDCAP,
    S_DONE
  } okl_state_e;

  // controller to datapath
  typedef struct packed {
    logic        latch;
    logic        scan_init;
    logic        scan_run;
    logic        shift_init;
    logic        shift_run;
    logic        do_append;
    logic        count_dec;
    logic        count_clr;
    logic        rd_pos;
    logic        cap_rd;
    logic        cap_hit;
    logic        set_st;
    okl_status_e st_val;
    logic        out_load;
  } okl_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       handle_null;
    logic       hit;
    logic       scan_done;
    logic       full;
    logic       pos_oor;
    logic       out_free;
  } okl_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/ordered_keyed_list_table_unit.sv
// path to a valid result: clear, an out-of-range read and a null-handle append go from
//   decode to done, a read via a capture step; append, lookup and remove scan the table
// throughput: one transaction at a time, the next is taken the cycle after the result is
//   loaded; the key scan and the shift on removal handle one entry per cycle
// reset: asynchronous, active low; empties the table, no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module ordered_keyed_list_table_unit import okl_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic        [2:0]  cmd_i,
  input  wire logic signed [31:0] item_id_i,
  input  wire logic        [31:0] item_handle_i,
  input  wire logic        [5:0]  position_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [2:0]  status_o,
  output logic             [31:0] found_handle_o,
  output logic signed      [31:0] found_id_o,
  output logic             [6:0]  entry_count_o,
  output logic                    is_empty_o
);

  okl_ctl_t ctl;
  okl_sts_t sts;

  okl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  okl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .item_id_i      (item_id_i),
    .item_handle_i  (item_handle_i),
    .position_i     (position_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .found_handle_o (found_handle_o),
    .found_id_o     (found_id_o),
    .entry_count_o  (entry_count_o),
    .is_empty_o     (is_empty_o),
    .ctl_i          (ctl),
    .sts_o          (sts)
  );

endmodule

`default_nettype wire

>>> hw/rtl/okl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module okl_ctrl import okl_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire okl_sts_t sts_i,
  output okl_ctl_t      ctl_o
);

  okl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    ctl_o.st_val = ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.cmd)
          CMD_APPEND: begin
            if (sts_i.handle_null) begin
              ctl_o.set_st = 1'b1;
              ctl_o.st_val = ST_NULL;
              state_d      = S_DONE;
            end else begin
              ctl_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
          end
          CMD_REMOVE, CMD_LOOKUP: begin
            ctl_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end
          CMD_READ: begin
            if (sts_i.pos_oor) begin
              ctl_o.set_st = 1'b1;
              ctl_o.st_val = ST_RANGE;
              state_d      = S_DONE;
            end else begin
              ctl_o.rd_pos = 1'b1;
              state_d      = S_RDCAP;
            end
          end
          CMD_CLEAR: begin
            ctl_o.count_clr = 1'b1;
            state_d         = S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        priority if (sts_i.hit) begin
          unique case (sts_i.cmd)
            CMD_APPEND: begin
              ctl_o.set_st = 1'b1;
              ctl_o.st_val = ST_DUP;
              state_d      = S_DONE;
            end
            CMD_REMOVE: begin
              ctl_o.cap_hit    = 1'b1;
              ctl_o.shift_init = 1'b1;
              state_d          = S_SHIFT;
            end
            default: begin
              ctl_o.cap_hit = 1'b1;
              state_d       = S_DONE;
            end
          endcase
        end else if (sts_i.scan_done) begin
          state_d = S_DONE;
          if (sts_i.cmd == CMD_APPEND) begin
            if (sts_i.full) begin
              ctl_o.set_st = 1'b1;
              ctl_o.st_val = ST_FULL;
            end else begin
              ctl_o.do_append = 1'b1;
            end
          end else begin
            ctl_o.set_st = 1'b1;
            ctl_o.st_val = ST_MISSING;
          end
        end else begin
          ctl_o.scan_run = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts_i.scan_done) begin
          ctl_o.count_dec = 1'b1;
          state_d         = S_DONE;
        end else begin
          ctl_o.shift_run = 1'b1;
        end
      end
      S_RDCAP: begin
        ctl_o.cap_rd = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/okl_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module okl_dp import okl_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic        [2:0]  cmd_i,
  input  wire logic signed [31:0] item_id_i,
  input  wire logic        [31:0] item_handle_i,
  input  wire logic        [5:0]  position_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic             [2:0]  status_o,
  output logic             [31:0] found_handle_o,
  output logic signed      [31:0] found_id_o,
  output logic             [6:0]  entry_count_o,
  output logic                    is_empty_o,
  input  wire okl_ctl_t           ctl_i,
  output okl_sts_t                sts_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // entry store: key in the upper half, handle in the lower half
  logic [63:0] mem [CAPACITY];

  logic [2:0]    cmd_q;
  logic [31:0]   key_q;
  logic [31:0]   handle_q;
  logic [5:0]    pos_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_idx_q, scan_idx_d;
  logic          rvalid_q, rvalid_d;
  logic [AW-1:0] idx_pipe_q, idx_pipe_d;
  logic [63:0]   rd_q;

  okl_status_e   st_q;
  logic [31:0]   res_handle_q;
  logic [31:0]   res_id_q;

  logic          out_valid_q;
  logic [2:0]    out_status_q;
  logic [31:0]   out_handle_q;
  logic [31:0]   out_id_q;
  logic [6:0]    out_count_q;
  logic          out_empty_q;

  logic          scan_lt_count;
  logic          issue;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;

  assign scan_lt_count = scan_idx_q < count_q;
  assign issue   = (ctl_i.scan_run || ctl_i.shift_run) && scan_lt_count;
  assign rd_en   = issue || ctl_i.rd_pos;
  assign rd_addr = ctl_i.rd_pos ? AW'(pos_q) : scan_idx_q[AW-1:0];

  // a shift moves the entry read last cycle down by one place
  assign we    = ctl_i.do_append || (ctl_i.shift_run && rvalid_q);
  assign waddr = ctl_i.do_append ? AW'(count_q) : idx_pipe_q - AW'(1);
  assign wdata = ctl_i.do_append ? {key_q, handle_q} : rd_q;

  always_comb begin
    scan_idx_d = scan_idx_q;
    rvalid_d   = 1'b0;
    idx_pipe_d = idx_pipe_q;
    if (ctl_i.scan_init) begin
      scan_idx_d = '0;
    end else if (ctl_i.shift_init) begin
      scan_idx_d = CW'(idx_pipe_q) + CW'(1);
    end else if (issue) begin
      scan_idx_d = scan_idx_q + CW'(1);
      rvalid_d   = 1'b1;
      idx_pipe_d = scan_idx_q[AW-1:0];
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.count_clr) begin
      count_d = '0;
    end else if (ctl_i.do_append) begin
      count_d = count_q + CW'(1);
    end else if (ctl_i.count_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rvalid_q    <= 1'b0;
      scan_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      rvalid_q   <= rvalid_d;
      scan_idx_q <= scan_idx_d;
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_pipe_q <= idx_pipe_d;
    if (ctl_i.latch) begin
      cmd_q        <= cmd_i;
      key_q        <= item_id_i;
      handle_q     <= item_handle_i;
      pos_q        <= position_i;
      st_q         <= ST_OK;
      res_handle_q <= '0;
      res_id_q     <= '0;
    end else begin
      if (ctl_i.set_st) begin
        st_q <= ctl_i.st_val;
      end
      if (ctl_i.cap_hit || ctl_i.cap_rd) begin
        res_handle_q <= rd_q[31:0];
      end
      if (ctl_i.cap_rd) begin
        res_id_q <= rd_q[63:32];
      end
    end
    if (ctl_i.out_load) begin
      out_status_q <= st_q;
      out_handle_q <= res_handle_q;
      out_id_q     <= res_id_q;
      out_count_q  <= 7'(count_q);
      out_empty_q  <= (count_q == '0);
    end
  end

  always_comb begin
    sts_o.cmd         = cmd_q;
    sts_o.handle_null = (handle_q == '0);
    sts_o.hit         = rvalid_q && (rd_q[63:32] == key_q);
    sts_o.scan_done   = !scan_lt_count && !rvalid_q;
    sts_o.full        = (count_q == CW'(CAPACITY));
    sts_o.pos_oor     = (CW + 6)'(pos_q) >= (CW + 6)'(count_q);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_handle_o = out_handle_q;
  assign found_id_o     = out_id_q;
  assign entry_count_o  = out_count_q;
  assign is_empty_o     = out_empty_q;

endmodule

`default_nettype wire

>>> hw/rtl/okl_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module okl_chk import okl_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_o,
  input wire logic [31:0] found_handle_o,
  input wire logic [31:0] found_id_o,
  input wire logic [6:0]  entry_count_o,
  input wire logic        is_empty_o
);

  `ASSERT_AT(a_empty_flag, clk_i, rst_ni, out_valid_o |-> (is_empty_o == (entry_count_o == 7'd0)), "empty flag disagrees with entry count")
  `ASSERT_AT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "new transaction taken while one is in progress")
  `ASSERT_AT(a_reject_zero_fields, clk_i, rst_ni, (out_valid_o && status_o != ST_OK) |-> (found_handle_o == 32'd0 && found_id_o == 32'd0), "found fields set on a failed command")
  `ASSERT_NEVER(a_status_code, clk_i, rst_ni, out_valid_o && (status_o == 3'd6 || status_o == 3'd7), "unknown status code")
  `ASSERT_AT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o) && $stable(entry_count_o)), "result dropped while stalled")

endmodule

bind ordered_keyed_list_table_unit okl_chk u_okl_chk (.*);

`default_nettype wire

>>> tb/sv/tb_ordered_keyed_list_table_unit.sv
`timescale 1ns / 1ps

module tb_ordered_keyed_list_table_unit;
  import okl_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 5 + 2 * TABLE_DEPTH + 20;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    okl_status_e status;
    logic [31:0] handle;
    logic [31:0] id;
    logic [6:0]  count;
    logic        empty;
  } table_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [2:0] cmd_i;
  logic signed [31:0] item_id_i;
  logic [31:0] item_handle_i;
  logic [5:0] position_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [2:0] status_o;
  logic [31:0] found_handle_o;
  logic signed [31:0] found_id_o;
  logic [6:0] entry_count_o;
  logic is_empty_o;

  // shadow copy of the table contents
  logic [31:0] tbl_keys[TABLE_DEPTH];
  logic [31:0] tbl_handles[TABLE_DEPTH];
  int tbl_count;

  table_reply_t table_replies_q[$];
  table_reply_t reply_want;
  int mismatch_count;
  int stall_cycles = 0;
  int out_hold_cycles;
  bit in_idle_on;
  bit out_idle_on;

  ordered_keyed_list_table_unit #(
    .CAPACITY(TABLE_DEPTH)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_i(cmd_i),
    .item_id_i(item_id_i),
    .item_handle_i(item_handle_i),
    .position_i(position_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o(status_o),
    .found_handle_o(found_handle_o),
    .found_id_o(found_id_o),
    .entry_count_o(entry_count_o),
    .is_empty_o(is_empty_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int table_find(input logic [31:0] key);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_keys[i] == key) return i;
    end
    return tbl_count;
  endfunction

  // applies one command to the shadow table and returns the reply it should give
  function automatic table_reply_t table_apply(input logic [2:0] c, input logic [31:0] id,
                                               input logic [31:0] h, input logic [5:0] p);
    table_reply_t r;
    int slot;
    r = '0;
    slot = table_find(id);
    case (c)
      CMD_APPEND: begin
        if (h == '0) begin
          r.status = ST_NULL;
        end else if (slot < tbl_count) begin
          r.status = ST_DUP;
        end else if (tbl_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tbl_keys[tbl_count] = id;
          tbl_handles[tbl_count] = h;
          tbl_count++;
        end
      end
      CMD_REMOVE: begin
        if (slot >= tbl_count) begin
          r.status = ST_MISSING;
        end else begin
          r.handle = tbl_handles[slot];
          // later entries close the gap
          for (int i = slot; i + 1 < tbl_count; i++) begin
            tbl_keys[i] = tbl_keys[i + 1];
            tbl_handles[i] = tbl_handles[i + 1];
          end
          tbl_count--;
        end
      end
      CMD_LOOKUP: begin
        if (slot >= tbl_count) r.status = ST_MISSING;
        else r.handle = tbl_handles[slot];
      end
      CMD_READ: begin
        if (int'(p) >= tbl_count) begin
          r.status = ST_RANGE;
        end else begin
          r.handle = tbl_handles[p];
          r.id = tbl_keys[p];
        end
      end
      CMD_CLEAR: begin
        tbl_count = 0;
      end
      default: begin
      end
    endcase
    r.count = 7'(tbl_count);
    r.empty = (tbl_count == 0);
    return r;
  endfunction

  // offers one command and records its predicted reply once accepted
  task automatic send_cmd(input logic [2:0] c, input logic [31:0] id, input logic [31:0] h,
                          input logic [5:0] p);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 16) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    cmd_i = c;
    item_id_i = id;
    item_handle_i = h;
    position_i = p;
    do @(posedge clk_i); while (!in_ready_o);
    table_replies_q.push_back(table_apply(c, id, h, p));
  endtask

  function automatic logic [31:0] pick_id();
    if (tbl_count > 0 && $urandom_range(0, 99) < 65) begin
      return tbl_keys[$urandom_range(0, tbl_count - 1)];
    end
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 31));
      1: return -32'($urandom_range(1, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_handle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return '0;
    if (roll < 10) return '1;
    return $urandom;
  endfunction

  function automatic logic [5:0] pick_position();
    if (tbl_count > 0 && $urandom_range(0, 99) < 70) begin
      return 6'($urandom_range(0, tbl_count - 1));
    end
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic test_empty_table();
    send_cmd(CMD_READ, '0, '0, '0);
    send_cmd(CMD_LOOKUP, 32'd5, '0, '0);
    send_cmd(CMD_REMOVE, 32'd5, '0, '0);
    send_cmd(CMD_CLEAR, '0, '0, '0);
  endtask

  task automatic test_basic_commands();
    send_cmd(CMD_APPEND, 32'd3, '0, '0);
    send_cmd(CMD_APPEND, 32'h8000_0000, 32'hFFFF_FFFF, '0);
    send_cmd(CMD_APPEND, 32'h7FFF_FFFF, 32'd1, '0);
    send_cmd(CMD_APPEND, 32'hFFFF_FFFF, 32'hA5A5_5A5A, '0);
    // null handle is reported ahead of a duplicate id
    send_cmd(CMD_APPEND, 32'h8000_0000, '0, '0);
    send_cmd(CMD_APPEND, 32'h8000_0000, 32'd9, '0);
    send_cmd(CMD_READ, '0, '0, 6'd0);
    send_cmd(CMD_READ, '0, '0, 6'd2);
    send_cmd(CMD_READ, '0, '0, 6'd3);
    send_cmd(CMD_READ, '0, '0, 6'd63);
    send_cmd(CMD_LOOKUP, 32'h7FFF_FFFF, '0, '0);
    send_cmd(CMD_LOOKUP, 32'd0, '0, '0);
    send_cmd(CMD_REMOVE, 32'h8000_0000, '0, '0);
    send_cmd(CMD_READ, '0, '0, 6'd0);
    send_cmd(CMD_SPARE_FIRST, 32'd1, 32'd1, 6'd1);
    send_cmd(CMD_SPARE_FIRST + 3'd1, '1, '1, '1);
    send_cmd(CMD_SPARE_LAST, '1, '1, '1);
    send_cmd(CMD_CLEAR, '0, '0, '0);
    send_cmd(CMD_READ, '0, '0, 6'd0);
  endtask

  task automatic test_full_table();
    logic [31:0] id;
    send_cmd(CMD_CLEAR, '0, '0, '0);
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      id = {6'(k), 26'($urandom)};
      send_cmd(CMD_APPEND, id, pick_handle() | 32'd1, '0);
    end
    send_cmd(CMD_APPEND, 32'h1234_5678 ^ $urandom, $urandom | 32'd1, '0);
    send_cmd(CMD_APPEND, tbl_keys[TABLE_DEPTH - 1], 32'd7, '0);
    send_cmd(CMD_APPEND, $urandom, '0, '0);
    send_cmd(CMD_READ, '0, '0, 6'd63);
    send_cmd(CMD_LOOKUP, tbl_keys[TABLE_DEPTH - 1], '0, '0);
    send_cmd(CMD_REMOVE, tbl_keys[0], '0, '0);
    send_cmd(CMD_READ, '0, '0, 6'd63);
    send_cmd(CMD_APPEND, 32'hDEAD_0001, 32'h0000_0100, '0);
  endtask

  task automatic test_random_traffic(input int n, input int append_pct,
                                     input int clear_per_mille);
    int unsigned roll;
    logic [2:0] c;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 999);
      if (roll < clear_per_mille) begin
        c = CMD_CLEAR;
      end else if (roll < clear_per_mille + 30) begin
        c = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < append_pct) c = CMD_APPEND;
        else if (roll % 3 == 0) c = CMD_REMOVE;
        else if (roll % 3 == 1) c = CMD_LOOKUP;
        else c = CMD_READ;
      end
      send_cmd(c, pick_id(), pick_handle(), pick_position());
    end
  endtask

  // receiver stalls for a long stretch while commands keep coming
  task automatic test_output_backpressure();
    in_idle_on = 1'b0;
    out_hold_cycles = HOLD_OFF_CYCLES;
    test_random_traffic(16, 50, 0);
  endtask

  // receiver: per result draws a random stall when out_idle_on is set, or takes a requested hold-off
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      int wait_cycles;
      wait_cycles = out_idle_on ? $urandom_range(0, 16) : 0;
      if (out_hold_cycles > 0) begin
        wait_cycles = out_hold_cycles;
        out_hold_cycles = 0;
      end
      @(negedge clk_i);
      if (wait_cycles > 0) begin
        out_ready_i = 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%08h actual 0x%08h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (table_replies_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual status %0d", $time, status_o);
      end else begin
        reply_want = table_replies_q.pop_front();
        check_field("status", 32'(reply_want.status), 32'(status_o));
        check_field("found_handle", reply_want.handle, found_handle_o);
        check_field("found_id", reply_want.id, found_id_o);
        check_field("entry_count", 32'(reply_want.count), 32'(entry_count_o));
        check_field("is_empty", 32'(reply_want.empty), 32'(is_empty_o));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = '0;
    item_id_i = '0;
    item_handle_i = '0;
    position_i = '0;
    tbl_count = 0;
    mismatch_count = 0;
    out_hold_cycles = 0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_table();
    test_basic_commands();
    test_full_table();
    test_random_traffic(400, 50, 10);
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    test_random_traffic(400, 60, 5);
    test_output_backpressure();
    in_idle_on = 1'b1;
    test_random_traffic(300, 40, 20);
    in_idle_on = 1'b0;
    out_idle_on = 1'b1;
    test_random_traffic(300, 30, 10);
    in_idle_on = 1'b1;
    test_random_traffic(300, 45, 10);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (table_replies_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> ordered_keyed_list_table_unit.f
+incdir+hw/rtl
hw/rtl/okl_pkg.sv
hw/rtl/okl_ctrl.sv
hw/rtl/okl_dp.sv
hw/rtl/ordered_keyed_list_table_unit.sv
hw/rtl/okl_chk.sv
tb/sv/tb_ordered_keyed_list_table_unit.sv
